// ===== hw/rtl/gwsha_pkg.sv =====
// ----------------------------------------------------------------------------
// gwsha_pkg
// Shared constants, codes and types of the gate word stream hit aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package gwsha_pkg;

   localparam int HitSlotsDefault = 32;

   // word identifiers
   localparam logic [3:0] ID_HEADER   = 4'd0;
   localparam logic [3:0] ID_TS1      = 4'd1;
   localparam logic [3:0] ID_TIME     = 4'd2;
   localparam logic [3:0] ID_AMP      = 4'd3;
   localparam logic [3:0] ID_TS4      = 4'd4;
   localparam logic [3:0] ID_TS5      = 4'd5;
   localparam logic [3:0] ID_TRAILER  = 4'd6;
   localparam logic [3:0] ID_GATETIME = 4'd7;
   localparam logic [3:0] ID_FEB      = 4'd13;

   // record kinds
   localparam logic [1:0] KIND_SUMMARY = 2'd0;
   localparam logic [1:0] KIND_HIT     = 2'd1;
   localparam logic [1:0] KIND_ECHO    = 2'd2;

   // presence bit positions
   localparam int P_A = 8;
   localparam int P_B = 7;
   localparam int P_OPEN = 6;
   localparam int P_TRL = 5;
   localparam int P_CLOSE = 4;
   localparam int P_FEB = 3;
   localparam int P_FIRST = 2;
   localparam int P_LAST = 1;
   localparam int P_OVF = 0;

   // one result record
   typedef struct packed {
      logic [1:0]  record_kind;
      logic        last_of_run;
      logic [15:0] gate_id;
      logic [23:0] ident;
      logic [27:0] time_first;
      logic [27:0] time_second;
      logic [8:0]  flags;
      logic [51:0] detail;
      logic [37:0] counts;
      logic [48:0] anchor_first;
      logic [48:0] anchor_last;
   } rec_type;

   // hit slot contents: times and amplitudes with counters
   typedef struct packed {
      logic [7:0]  te_cnt;
      logic [7:0]  le_cnt;
      logic        te_ok;
      logic        le_ok;
      logic [12:0] te;
      logic [12:0] le;
   } slot_time_type;

   typedef struct packed {
      logic [7:0]  lg_cnt;
      logic [7:0]  hg_cnt;
      logic        lg_ok;
      logic        hg_ok;
      logic [11:0] lg;
      logic [11:0] hg;
   } slot_amp_type;

   function automatic logic [7:0] sat8(input logic [7:0] v);
      sat8 = (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gate_word_stream_hit_aggregator_core.sv =====
// ----------------------------------------------------------------------------
// gate_word_stream_hit_aggregator_core
// Gathers one gate of front-end words into a summary and hit rows, and echoes timestamp words.
// ----------------------------------------------------------------------------
// Word handling: header, trailer, gate time, ignored and zero words are
// taken in the idle state, except that a header A on an open gate starts a
// flush. A timestamp word waits for the result register to be free. A time
// or amplitude word scans the slot memory for its key through the single
// read port, in two steps per slot compared (read, then compare and write
// back), from the shortest case (new key, empty table) up to a scan of every
// used slot. A flush holds the input for the summary and then sends one hit
// row per cycle while the result side is ready. The result register lets the
// next word be taken while a result still waits.
`default_nettype none

module gate_word_stream_hit_aggregator_core
   import gwsha_pkg::*;
#(
   parameter int HIT_SLOTS = HitSlotsDefault,
   localparam int AW = (HIT_SLOTS > 1) ? $clog2(HIT_SLOTS) : 1,
   localparam int CW = $clog2(HIT_SLOTS + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,   // word[31:0]
   input  wire logic          req_tuser,   // mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic               rsp_tlast,   // last_of_run
   output logic [1:0]         rsp_tuser,   // record_kind
   // gate_id, ident, time_first, time_second, flags, detail, counts,
   // anchor_first, anchor_last (low to high), 293 bits padded to 296
   output logic [295:0]       rsp_tdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_FSUM  = 3'd3;
   localparam logic [2:0] ST_FROW  = 3'd4;
   localparam logic [2:0] ST_ECHO  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic        reopen_ff, reopen_in;  // header A follows flush
   logic        gate_open_ff, gate_open_in;
   logic        after_trl_ff, after_trl_in;
   logic [63:0] hdr_ff, hdr_in;
   logic [53:0] trl_ff, trl_in;
   logic [55:0] times_ff, times_in;
   logic [8:0]  pres_ff, pres_in;
   logic [48:0] fa_ff, fa_in;
   logic [48:0] la_ff, la_in;
   logic [31:0] wc_ff, wc_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] idx_ff, idx_in;     // scan / flush pointer
   logic        rd_pend_ff, rd_pend_in;
   rec_type     out_ff, out_in;
   logic        ov_ff, ov_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [12:0]   wr_key, rd_key;
   slot_time_type wr_time, rd_time;
   slot_amp_type  wr_amp, rd_amp;

   gwsha_slot_ram #(.HIT_SLOTS(HIT_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .wr_time (wr_time),
      .wr_amp  (wr_amp),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_time (rd_time),
      .rd_amp  (rd_amp)
   );

   logic out_free;
   logic [3:0] wid;
   logic [12:0] wkey;
   rec_type sum_rec, row_rec, echo_rec;
   slot_time_type mt;
   slot_amp_type  ma;
   logic [2:0] acode;

   assign out_free   = !ov_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign wid  = word_ff[31:28];
   assign wkey = word_ff[27:15];
   assign acode = word_ff[14:12];

   // summary record from gate state
   always_comb begin
      sum_rec = '0;
      sum_rec.record_kind = KIND_SUMMARY;
      sum_rec.gate_id = hdr_ff[15:0];
      sum_rec.ident = {hdr_ff[26:19], hdr_ff[34:27], trl_ff[26:19]};
      sum_rec.time_first = times_ff[27:0];
      sum_rec.time_second = times_ff[55:28];
      sum_rec.flags = pres_ff;
      sum_rec.detail = {hdr_ff[18:16], hdr_ff[45:35], trl_ff[18:16], trl_ff[15:0],
                        trl_ff[45], trl_ff[44], trl_ff[43], trl_ff[42:27]};
      sum_rec.counts = {6'(used_ff), wc_ff};
      sum_rec.anchor_first = fa_ff;
      sum_rec.anchor_last = la_ff;
      sum_rec.last_of_run = (used_ff == '0);
   end

   // hit row from memory read data
   always_comb begin
      row_rec = '0;
      row_rec.record_kind = KIND_HIT;
      row_rec.gate_id = hdr_ff[15:0];
      row_rec.ident = {11'd0, rd_key};
      row_rec.time_first = {15'd0, rd_time.le};
      row_rec.time_second = {15'd0, rd_time.te};
      row_rec.flags = {5'd0, rd_time.le_ok, rd_time.te_ok, rd_amp.hg_ok, rd_amp.lg_ok};
      row_rec.detail = {28'd0, rd_amp.hg, rd_amp.lg};
      row_rec.counts = {6'd0, rd_time.le_cnt, rd_time.te_cnt, rd_amp.hg_cnt,
                        rd_amp.lg_cnt};
      row_rec.last_of_run = (idx_ff == used_ff);
   end

   // timestamp echo
   always_comb begin
      echo_rec = '0;
      echo_rec.record_kind = KIND_ECHO;
      echo_rec.last_of_run = 1'b1;
      echo_rec.gate_id = hdr_ff[15:0];
      echo_rec.flags[1] = !after_trl_ff;
      unique case (wid)
         ID_TS1: begin
            echo_rec.time_first = word_ff[27:0];
         end
         ID_TS4: begin
            echo_rec.flags[3:2] = 2'd1;
            echo_rec.time_first = word_ff[27:0];
         end
         default: begin
            echo_rec.flags[3:2] = 2'd2;
            echo_rec.time_first = la_ff[48:21];
            echo_rec.time_second = {8'd0, word_ff[19:0]};
            echo_rec.flags[0] = word_ff[27];
         end
      endcase
   end

   // slot update for time or amplitude word on read data
   always_comb begin
      mt = (rd_pend_ff) ? rd_time : '0;
      ma = (rd_pend_ff) ? rd_amp : '0;
      if (wid == ID_TIME) begin
         if (!word_ff[14]) begin
            mt.le_cnt = sat8(mt.le_cnt);
            if (!mt.le_ok || word_ff[12:0] < mt.le) mt.le = word_ff[12:0];
            mt.le_ok = 1'b1;
         end else begin
            mt.te_cnt = sat8(mt.te_cnt);
            if (!mt.te_ok || word_ff[12:0] > mt.te) mt.te = word_ff[12:0];
            mt.te_ok = 1'b1;
         end
      end else if (acode == 3'd2) begin
         ma.hg_cnt = sat8(ma.hg_cnt);
         ma.hg = word_ff[11:0];
         ma.hg_ok = 1'b1;
      end else if (acode == 3'd3) begin
         ma.lg_cnt = sat8(ma.lg_cnt);
         ma.lg = word_ff[11:0];
         ma.lg_ok = 1'b1;
      end
   end

   // control sequencer
   always_comb begin
      state_in = state_ff;
      word_in = word_ff;
      reopen_in = reopen_ff;
      gate_open_in = gate_open_ff;
      after_trl_in = after_trl_ff;
      hdr_in = hdr_ff;
      trl_in = trl_ff;
      times_in = times_ff;
      pres_in = pres_ff;
      fa_in = fa_ff;
      la_in = la_ff;
      wc_in = wc_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      rd_pend_in = 1'b0;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_tready;
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_key = wkey;
      wr_time = mt;
      wr_amp = ma;
      rd_addr = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               word_in = req_tdata;
               idx_in = '0;
               if (req_tuser) begin
                  reopen_in = 1'b0;
                  if (gate_open_ff) state_in = ST_FSUM;
               end else if (req_tdata == 32'h0000_0000) begin
                  state_in = ST_IDLE;
               end else if (req_tdata[31:28] == ID_HEADER && !req_tdata[19]) begin
                  reopen_in = 1'b1;
                  if (gate_open_ff) begin
                     state_in = ST_FSUM;
                  end else begin
                     gate_open_in = 1'b1;
                     hdr_in = {37'd0, req_tdata[27:20], req_tdata[18:0]};
                     hdr_in[63:27] = '0;
                     hdr_in[26:19] = req_tdata[27:20];
                     hdr_in[18:16] = req_tdata[18:16];
                     hdr_in[15:0] = req_tdata[15:0];
                     pres_in = 9'd0;
                     pres_in[P_A] = 1'b1;
                  end
               end else if (gate_open_ff) begin
                  case (req_tdata[31:28]) inside
                     ID_HEADER: begin
                        hdr_in[34:27] = req_tdata[27:20];
                        hdr_in[45:35] = req_tdata[10:0];
                        pres_in[P_B] = 1'b1;
                     end
                     ID_GATETIME: begin
                        if (!after_trl_ff) begin
                           times_in[27:0] = req_tdata[27:0];
                           pres_in[P_OPEN] = 1'b1;
                        end else begin
                           times_in[55:28] = req_tdata[27:0];
                           pres_in[P_CLOSE] = 1'b1;
                        end
                     end
                     ID_TRAILER: begin
                        trl_in[15:0] = req_tdata[15:0];
                        trl_in[18:16] = req_tdata[18:16];
                        trl_in[26:19] = req_tdata[27:20];
                        pres_in[P_TRL] = 1'b1;
                        after_trl_in = 1'b1;
                     end
                     ID_TIME: begin
                        if (wc_ff[31:16] != 16'hFFFF) wc_in[31:16] = wc_ff[31:16] + 16'd1;
                        state_in = ST_SCAN;
                     end
                     ID_AMP: begin
                        if (wc_ff[15:0] != 16'hFFFF) wc_in[15:0] = wc_ff[15:0] + 16'd1;
                        state_in = ST_SCAN;
                     end
                     ID_TS1, ID_TS4, ID_TS5: state_in = ST_ECHO;
                     ID_FEB: begin
                        trl_in[42:27] = req_tdata[15:0];
                        trl_in[45:43] = {req_tdata[18], req_tdata[17], req_tdata[16]};
                        pres_in[P_FEB] = 1'b1;
                        reopen_in = 1'b0;
                        state_in = ST_FSUM;
                     end
                     default: state_in = ST_IDLE;
                  endcase
               end
            end
         end

         // read slot idx, compare next cycle
         ST_SCAN: begin
            if (idx_ff == used_ff) begin
               if (used_ff == CW'(HIT_SLOTS)) begin
                  pres_in[P_OVF] = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  used_in = used_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end else begin
               rd_addr = idx_ff[AW-1:0];
               state_in = ST_MOD;
            end
         end

         ST_MOD: begin
            rd_pend_in = 1'b0;
            if (rd_key == wkey) begin
               wr_en = 1'b1;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
               state_in = ST_SCAN;
            end
         end

         ST_ECHO: begin
            if (out_free) begin
               out_in = echo_rec;
               ov_in = 1'b1;
               state_in = ST_IDLE;
               if (wid == ID_TS4) begin
                  la_in[48:21] = word_ff[27:0];
                  pres_in[P_LAST] = 1'b1;
               end else if (wid == ID_TS5) begin
                  la_in[20:0] = {word_ff[19:0], word_ff[27]};
                  pres_in[P_LAST] = 1'b1;
                  if (!after_trl_ff && !pres_ff[P_FIRST]) begin
                     fa_in = {la_ff[48:21], word_ff[19:0], word_ff[27]};
                     pres_in[P_FIRST] = 1'b1;
                  end
               end
            end
         end

         ST_FSUM: begin
            rd_addr = '0;
            if (out_free) begin
               out_in = sum_rec;
               ov_in = 1'b1;
               idx_in = CW'(1);
               rd_pend_in = (used_ff != '0);
               state_in = (used_ff != '0) ? ST_FROW : ST_IDLE;
            end else begin
               rd_pend_in = 1'b0;
            end
         end

         // rd data holds slot idx-1
         ST_FROW: begin
            rd_addr = idx_ff[AW-1:0];
            if (!rd_pend_ff) begin
               rd_addr = AW'(idx_ff - CW'(1));
               rd_pend_in = 1'b1;
            end else if (out_free) begin
               out_in = row_rec;
               ov_in = 1'b1;
               if (idx_ff == used_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + CW'(1);
                  rd_pend_in = 1'b1;
               end
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               rd_pend_in = 1'b1;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // clear gate after a flush, reopen on header A
      if ((state_ff == ST_FSUM || state_ff == ST_FROW) && state_in == ST_IDLE) begin
         gate_open_in = reopen_ff;
         after_trl_in = 1'b0;
         trl_in = '0;
         times_in = '0;
         fa_in = '0;
         la_in = '0;
         wc_in = '0;
         used_in = '0;
         pres_in = '0;
         hdr_in = '0;
         if (reopen_ff) begin
            hdr_in[26:19] = word_ff[27:20];
            hdr_in[18:16] = word_ff[18:16];
            hdr_in[15:0] = word_ff[15:0];
            pres_in[P_A] = 1'b1;
         end
      end
   end

   // hit update: start value for a new slot is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gate_open_ff <= 1'b0;
         after_trl_ff <= 1'b0;
         hdr_ff <= '0;
         trl_ff <= '0;
         times_ff <= '0;
         pres_ff <= '0;
         fa_ff <= '0;
         la_ff <= '0;
         wc_ff <= '0;
         used_ff <= '0;
         ov_ff <= 1'b0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gate_open_ff <= gate_open_in;
         after_trl_ff <= after_trl_in;
         hdr_ff <= hdr_in;
         trl_ff <= trl_in;
         times_ff <= times_in;
         pres_ff <= pres_in;
         fa_ff <= fa_in;
         la_ff <= la_in;
         wc_ff <= wc_in;
         used_ff <= used_in;
         ov_ff <= ov_in;
         rd_pend_ff <= rd_pend_in || (state_in == ST_MOD);
      end
      word_ff <= word_in;
      reopen_ff <= reopen_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = out_ff.last_of_run;
   assign rsp_tuser  = out_ff.record_kind;
   assign rsp_tdata  = {3'b000, out_ff.anchor_last, out_ff.anchor_first, out_ff.counts,
                        out_ff.detail, out_ff.flags, out_ff.time_second,
                        out_ff.time_first, out_ff.ident, out_ff.gate_id};

endmodule

`default_nettype wire

// ===== hw/rtl/gwsha_slot_ram.sv =====
// ----------------------------------------------------------------------------
// gwsha_slot_ram
// Hit slot memory: key, time and amplitude per slot, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gwsha_slot_ram
   import gwsha_pkg::*;
#(
   parameter int HIT_SLOTS = HitSlotsDefault,
   localparam int AW = (HIT_SLOTS > 1) ? $clog2(HIT_SLOTS) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [12:0]         wr_key,
   input  wire slot_time_type       wr_time,
   input  wire slot_amp_type        wr_amp,
   input  wire logic [AW-1:0]       rd_addr,
   output logic [12:0]              rd_key,
   output slot_time_type            rd_time,
   output slot_amp_type             rd_amp
);

   logic [12:0]   key_mem  [HIT_SLOTS];
   slot_time_type time_mem [HIT_SLOTS];
   slot_amp_type  amp_mem  [HIT_SLOTS];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_key;
         time_mem[wr_addr] <= wr_time;
         amp_mem[wr_addr]  <= wr_amp;
      end
      rd_key  <= key_mem[rd_addr];
      rd_time <= time_mem[rd_addr];
      rd_amp  <= amp_mem[rd_addr];
   end

endmodule

`default_nettype wire
